/* rtl/core/pjc_pkg.sv */
// Package for the planar joint constraint evaluator: widths, codes,
// shared record types, the quarter-wave sine table and rounding helpers.
// No dependencies.
`timescale 1ns / 1ps

package pjc_pkg;

   localparam int ANGLE_BITS = 16;
   localparam int FRAC_BITS  = 16;
   localparam int MAX_ROWS   = 2;
   localparam int ROW_W      = $clog2(MAX_ROWS);

   localparam int SW  = 17;   // Q1.15 sine/cosine, signed
   localparam int MW  = 49;   // trig times anchor
   localparam int RW  = 35;   // rotated anchor
   localparam int DW  = 38;   // separation and carried anchors
   localparam int HW  = 19;   // low half of a split operand
   localparam int PW  = 76;   // wide products and sums
   localparam int OW  = 48;   // result fields

   localparam logic [1:0] MODE_DISTANCE = 2'd0;
   localparam logic [1:0] MODE_REVOLUTE = 2'd1;

   typedef enum logic [2:0] {
      CSR_JOINT_MODE      = 3'd0,
      CSR_ANCHOR_I_X      = 3'd1,
      CSR_ANCHOR_I_Y      = 3'd2,
      CSR_ANCHOR_J_X      = 3'd3,
      CSR_ANCHOR_J_Y      = 3'd4,
      CSR_TARGET_DISTANCE = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] px_i;
      logic signed [31:0] py_i;
      logic signed [31:0] px_j;
      logic signed [31:0] py_j;
   } pos_type;

   typedef struct packed {
      logic signed [SW-1:0] s_i;
      logic signed [SW-1:0] c_i;
      logic signed [SW-1:0] s_j;
      logic signed [SW-1:0] c_j;
   } trig_type;

   typedef struct packed {
      logic signed [DW-1:0] dx;
      logic signed [DW-1:0] dy;
      logic signed [DW-1:0] rix;
      logic signed [DW-1:0] riy;
      logic signed [DW-1:0] rjx;
      logic signed [DW-1:0] rjy;
   } geom_type;

   typedef struct packed {
      logic signed [OW-1:0] resid;
      logic signed [OW-1:0] ja;
      logic signed [OW-1:0] jb;
      geom_type             g;
   } eval_type;

   localparam logic [15:0] QSINE [65] = '{
      16'd0,     16'd804,   16'd1608,  16'd2410,  16'd3212,  16'd4011,  16'd4808,  16'd5602,
      16'd6393,  16'd7179,  16'd7962,  16'd8739,  16'd9512,  16'd10278, 16'd11039, 16'd11793,
      16'd12539, 16'd13279, 16'd14010, 16'd14732, 16'd15446, 16'd16151, 16'd16846, 16'd17530,
      16'd18204, 16'd18868, 16'd19519, 16'd20159, 16'd20787, 16'd21403, 16'd22005, 16'd22594,
      16'd23170, 16'd23731, 16'd24279, 16'd24811, 16'd25329, 16'd25832, 16'd26319, 16'd26790,
      16'd27245, 16'd27683, 16'd28105, 16'd28510, 16'd28898, 16'd29268, 16'd29621, 16'd29956,
      16'd30273, 16'd30571, 16'd30852, 16'd31113, 16'd31356, 16'd31580, 16'd31785, 16'd31971,
      16'd32137, 16'd32285, 16'd32412, 16'd32521, 16'd32609, 16'd32678, 16'd32728, 16'd32757,
      16'd32767
   };

   // Angle scaled to a 24-bit phase.
   function automatic logic [23:0] to_phase(input logic [15:0] angle);
      logic [23:0] masked;
      masked = {8'd0, angle} & ((24'd1 << ANGLE_BITS) - 24'd1);
      return masked << (24 - ANGLE_BITS);
   endfunction

   // Table sine with linear interpolation, Q1.15.
   function automatic logic signed [SW-1:0] sine_q15(input logic [23:0] phase);
      logic [22:0] p;
      logic [6:0]  idx;
      logic [15:0] frac;
      logic [15:0] step;
      logic [26:0] prod;
      logic [15:0] mag;
      p = phase[22] ? (23'h400000 - {1'b0, phase[21:0]}) : {1'b0, phase[21:0]};
      idx  = p[22:16];
      frac = p[15:0];
      if (idx[6]) begin
         mag = QSINE[64];
      end else begin
         step = QSINE[idx[5:0] + 7'd1] - QSINE[idx[5:0]];
         prod = 27'(step) * 27'(frac) + 27'd32768;
         mag  = QSINE[idx[5:0]] + 16'(prod[26:16]);
      end
      return phase[23] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   endfunction

   // Round half up by n bits and saturate to the result width.
   function automatic logic signed [OW-1:0] round_sat(input logic signed [PW-1:0] w,
                                                      input int n);
      logic signed [PW:0] t;
      t = $signed({w[PW-1], w}) + $signed((PW+1)'(1) << (n - 1));
      t = t >>> n;
      if (t > $signed((PW+1)'({1'b0, {(OW-1){1'b1}}}))) begin
         return {1'b0, {(OW-1){1'b1}}};
      end else if (t < -$signed((PW+1)'({1'b1, {(OW-1){1'b0}}}))) begin
         return {1'b1, {(OW-1){1'b0}}};
      end
      return t[OW-1:0];
   endfunction

endpackage

/* rtl/core/pjc_if.sv */
// Stream interfaces for the request and response channels.
// Depends on pjc_pkg for widths.
`timescale 1ns / 1ps

interface pjc_req_if;
   import pjc_pkg::*;
   logic               valid;
   logic               ready;
   logic signed [31:0] first_pos_x;
   logic signed [31:0] first_pos_y;
   logic [15:0]        first_angle;
   logic signed [31:0] second_pos_x;
   logic signed [31:0] second_pos_y;
   logic [15:0]        second_angle;
   modport source (output valid, first_pos_x, first_pos_y, first_angle,
                   second_pos_x, second_pos_y, second_angle, input ready);
   modport sink (input valid, first_pos_x, first_pos_y, first_angle,
                 second_pos_x, second_pos_y, second_angle, output ready);
endinterface

interface pjc_rsp_if;
   import pjc_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [ROW_W-1:0]     row_index;
   logic signed [OW-1:0] residual_value;
   logic signed [OW-1:0] jac_first_x;
   logic signed [OW-1:0] jac_first_y;
   logic signed [OW-1:0] jac_first_angle;
   logic signed [OW-1:0] jac_second_x;
   logic signed [OW-1:0] jac_second_y;
   logic signed [OW-1:0] jac_second_angle;
   logic                 last_row;
   logic                 error_flag;
   modport source (output valid, row_index, residual_value, jac_first_x, jac_first_y,
                   jac_first_angle, jac_second_x, jac_second_y, jac_second_angle,
                   last_row, error_flag, input ready);
   modport sink (input valid, row_index, residual_value, jac_first_x, jac_first_y,
                 jac_first_angle, jac_second_x, jac_second_y, jac_second_angle,
                 last_row, error_flag, output ready);
endinterface

/* rtl/core/planar_joint_constraint_eval.sv */
// Top level of the planar joint constraint evaluator: configuration
// registers, pipeline enable and stage wiring.
// Depends on pjc_pkg, pjc_if, pjc_sincos, pjc_rotate, pjc_product, pjc_row_out.
//
//   channel   direction  beat contents
//   req_chan  in         two body poses (x, y, angle)
//   rsp_chan  out        one equation row: residual, six Jacobian terms, flags
//   csr_*     in         register write: index, 32-bit data
//
// An accepted request beat passes the stage registers of pjc_sincos, pjc_rotate
// and pjc_product, then the emitter's hold register presents its first row.
// A distance item gives one row a cycle while rsp_chan is ready; a revolute item
// holds the emitter for both its rows, so the single hold register sets the rate.
// Synchronous reset clears valid bits and sets config registers to reset values.
// A stall on rsp_chan with stage 7 full freezes all stages; no beat is lost or repeated.
`timescale 1ns / 1ps

module planar_joint_constraint_eval import pjc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   pjc_req_if.sink     req_chan,
   pjc_rsp_if.source   rsp_chan,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic [1:0]         joint_mode_ff;
   logic signed [31:0] anchor_i_x_ff;
   logic signed [31:0] anchor_i_y_ff;
   logic signed [31:0] anchor_j_x_ff;
   logic signed [31:0] anchor_j_y_ff;
   logic signed [31:0] target_distance_ff;

   logic     en;
   logic     free;
   logic     v1;
   logic     v4;
   logic     v7;
   pos_type  pos_in;
   pos_type  pos1;
   trig_type trig1;
   geom_type geom4;
   eval_type eval7;

   always_ff @(posedge clock) begin
      if (reset) begin
         joint_mode_ff      <= MODE_DISTANCE;
         anchor_i_x_ff      <= '0;
         anchor_i_y_ff      <= '0;
         anchor_j_x_ff      <= '0;
         anchor_j_y_ff      <= '0;
         target_distance_ff <= 32'sd65536;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_JOINT_MODE:      joint_mode_ff      <= csr_wdata[1:0];
            CSR_ANCHOR_I_X:      anchor_i_x_ff      <= csr_wdata;
            CSR_ANCHOR_I_Y:      anchor_i_y_ff      <= csr_wdata;
            CSR_ANCHOR_J_X:      anchor_j_x_ff      <= csr_wdata;
            CSR_ANCHOR_J_Y:      anchor_j_y_ff      <= csr_wdata;
            CSR_TARGET_DISTANCE: target_distance_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // The whole pipeline moves whenever its last stage is empty or drains.
   assign en = !v7 || free;
   assign req_chan.ready = en;

   always_comb begin
      pos_in.px_i = req_chan.first_pos_x;
      pos_in.py_i = req_chan.first_pos_y;
      pos_in.px_j = req_chan.second_pos_x;
      pos_in.py_j = req_chan.second_pos_y;
   end

   pjc_sincos u_sincos (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_chan.valid),
      .angle_i  (req_chan.first_angle),
      .angle_j  (req_chan.second_angle),
      .pos      (pos_in),
      .valid_ff (v1),
      .trig_ff  (trig1),
      .pos_ff   (pos1)
   );

   pjc_rotate u_rotate (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (v1),
      .trig       (trig1),
      .pos        (pos1),
      .anchor_i_x (anchor_i_x_ff),
      .anchor_i_y (anchor_i_y_ff),
      .anchor_j_x (anchor_j_x_ff),
      .anchor_j_y (anchor_j_y_ff),
      .valid_ff   (v4),
      .geom_ff    (geom4)
   );

   pjc_product u_product (
      .clock           (clock),
      .reset           (reset),
      .en              (en),
      .in_valid        (v4),
      .geom            (geom4),
      .target_distance (target_distance_ff),
      .valid_ff        (v7),
      .eval_ff         (eval7)
   );

   pjc_row_out u_row_out (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (v7),
      .eval            (eval7),
      .joint_mode      (joint_mode_ff),
      .target_distance (target_distance_ff),
      .free            (free),
      .rsp             (rsp_chan)
   );

endmodule

/* rtl/core/pjc_sincos.sv */
// Stage 1: sine and cosine of both body angles from the quarter-wave table.
// Depends on pjc_pkg.
`timescale 1ns / 1ps

module pjc_sincos import pjc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic [15:0] angle_i,
   input  logic [15:0] angle_j,
   input  pos_type     pos,
   output logic        valid_ff,
   output trig_type    trig_ff,
   output pos_type     pos_ff
);

   trig_type    trig_in;
   logic [23:0] ph_i;
   logic [23:0] ph_j;

   always_comb begin
      ph_i = to_phase(angle_i);
      ph_j = to_phase(angle_j);
      trig_in.s_i = sine_q15(ph_i);
      trig_in.c_i = sine_q15(ph_i + 24'h400000);
      trig_in.s_j = sine_q15(ph_j);
      trig_in.c_j = sine_q15(ph_j + 24'h400000);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         trig_ff <= trig_in;
         pos_ff  <= pos;
      end
   end

endmodule

/* rtl/core/pjc_rotate.sv */
// Stages 2 to 4: anchor rotation products, rounded rotated anchors,
// and the world-anchor separation. Depends on pjc_pkg.
`timescale 1ns / 1ps

module pjc_rotate import pjc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  trig_type           trig,
   input  pos_type            pos,
   input  logic signed [31:0] anchor_i_x,
   input  logic signed [31:0] anchor_i_y,
   input  logic signed [31:0] anchor_j_x,
   input  logic signed [31:0] anchor_j_y,
   output logic               valid_ff,
   output geom_type           geom_ff
);

   logic signed [MW-1:0] m_ff [8];
   logic signed [MW-1:0] m_in [8];
   pos_type              pos2_ff;
   pos_type              pos3_ff;
   logic signed [RW-1:0] r_ff [4];
   logic signed [RW-1:0] r_in [4];
   logic signed [MW:0]   acc [4];
   geom_type             geom_in;
   logic                 v2_ff;
   logic                 v3_ff;

   always_comb begin
      m_in[0] = MW'(trig.c_i) * MW'(anchor_i_x);
      m_in[1] = MW'(trig.s_i) * MW'(anchor_i_y);
      m_in[2] = MW'(trig.s_i) * MW'(anchor_i_x);
      m_in[3] = MW'(trig.c_i) * MW'(anchor_i_y);
      m_in[4] = MW'(trig.c_j) * MW'(anchor_j_x);
      m_in[5] = MW'(trig.s_j) * MW'(anchor_j_y);
      m_in[6] = MW'(trig.s_j) * MW'(anchor_j_x);
      m_in[7] = MW'(trig.c_j) * MW'(anchor_j_y);
   end

   // Rounding half up: add half an LSB, then shift arithmetically.
   always_comb begin
      acc[0] = (MW+1)'(m_ff[0]) - (MW+1)'(m_ff[1]) + (MW+1)'(1 << 14);
      acc[1] = (MW+1)'(m_ff[2]) + (MW+1)'(m_ff[3]) + (MW+1)'(1 << 14);
      acc[2] = (MW+1)'(m_ff[4]) - (MW+1)'(m_ff[5]) + (MW+1)'(1 << 14);
      acc[3] = (MW+1)'(m_ff[6]) + (MW+1)'(m_ff[7]) + (MW+1)'(1 << 14);
      for (int k = 0; k < 4; k++) begin
         r_in[k] = acc[k][MW:15];
      end
   end

   always_comb begin
      geom_in.rix = DW'(r_ff[0]);
      geom_in.riy = DW'(r_ff[1]);
      geom_in.rjx = DW'(r_ff[2]);
      geom_in.rjy = DW'(r_ff[3]);
      geom_in.dx  = DW'(pos3_ff.px_i) + DW'(r_ff[0]) - DW'(pos3_ff.px_j) - DW'(r_ff[2]);
      geom_in.dy  = DW'(pos3_ff.py_i) + DW'(r_ff[1]) - DW'(pos3_ff.py_j) - DW'(r_ff[3]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         valid_ff <= 1'b0;
      end else if (en) begin
         v2_ff    <= in_valid;
         v3_ff    <= v2_ff;
         valid_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff    <= m_in;
         pos2_ff <= pos;
         r_ff    <= r_in;
         pos3_ff <= pos2_ff;
         geom_ff <= geom_in;
      end
   end

endmodule

/* rtl/core/pjc_product.sv */
// Stages 5 to 7: split wide products, product assembly, and the rounded,
// saturated distance residual and angle derivatives. Depends on pjc_pkg.
`timescale 1ns / 1ps

module pjc_product import pjc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  geom_type           geom,
   input  logic signed [31:0] target_distance,
   output logic               valid_ff,
   output eval_type           eval_ff
);

   localparam int NL = 6;

   logic signed [DW-1:0]   op_a [NL];
   logic signed [DW-1:0]   op_b [NL];
   logic signed [2*HW-1:0] hh_in [NL];
   logic signed [2*HW:0]   hl_in [NL];
   logic signed [2*HW:0]   lh_in [NL];
   logic [2*HW-1:0]        ll_in [NL];
   logic signed [2*HW-1:0] hh_ff [NL];
   logic signed [2*HW:0]   hl_ff [NL];
   logic signed [2*HW:0]   lh_ff [NL];
   logic [2*HW-1:0]        ll_ff [NL];
   logic signed [PW-1:0]   p_in [NL];
   logic signed [PW-1:0]   p_ff [NL];
   logic signed [63:0]     tt_in;
   logic signed [63:0]     tt5_ff;
   logic signed [63:0]     tt6_ff;
   geom_type               g5_ff;
   geom_type               g6_ff;
   eval_type               eval_in;
   logic                   v5_ff;
   logic                   v6_ff;

   always_comb begin
      op_a[0] = geom.dx;  op_b[0] = geom.dx;
      op_a[1] = geom.dy;  op_b[1] = geom.dy;
      op_a[2] = geom.dx;  op_b[2] = geom.riy;
      op_a[3] = geom.dy;  op_b[3] = geom.rix;
      op_a[4] = geom.dx;  op_b[4] = geom.rjy;
      op_a[5] = geom.dy;  op_b[5] = geom.rjx;
      // Operands split into a signed high half and an unsigned low half.
      for (int k = 0; k < NL; k++) begin
         hh_in[k] = $signed(op_a[k][DW-1:HW]) * $signed(op_b[k][DW-1:HW]);
         hl_in[k] = $signed(op_a[k][DW-1:HW]) * $signed({1'b0, op_b[k][HW-1:0]});
         lh_in[k] = $signed({1'b0, op_a[k][HW-1:0]}) * $signed(op_b[k][DW-1:HW]);
         ll_in[k] = op_a[k][HW-1:0] * op_b[k][HW-1:0];
      end
      tt_in = target_distance * target_distance;
   end

   always_comb begin
      for (int k = 0; k < NL; k++) begin
         p_in[k] = (PW'(hh_ff[k]) <<< (2 * HW)) + (PW'(hl_ff[k]) <<< HW)
                 + (PW'(lh_ff[k]) <<< HW) + PW'({1'b0, ll_ff[k]});
      end
   end

   always_comb begin
      eval_in.resid = round_sat(p_ff[0] + p_ff[1] - PW'(tt6_ff), FRAC_BITS + 1);
      eval_in.ja    = round_sat(p_ff[3] - p_ff[2], FRAC_BITS);
      eval_in.jb    = round_sat(p_ff[4] - p_ff[5], FRAC_BITS);
      eval_in.g     = g6_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff    <= 1'b0;
         v6_ff    <= 1'b0;
         valid_ff <= 1'b0;
      end else if (en) begin
         v5_ff    <= in_valid;
         v6_ff    <= v5_ff;
         valid_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hh_ff   <= hh_in;
         hl_ff   <= hl_in;
         lh_ff   <= lh_in;
         ll_ff   <= ll_in;
         tt5_ff  <= tt_in;
         g5_ff   <= geom;
         p_ff    <= p_in;
         tt6_ff  <= tt5_ff;
         g6_ff   <= g5_ff;
         eval_ff <= eval_in;
      end
   end

endmodule

/* rtl/core/pjc_row_out.sv */
// Row emitter: holds one evaluated item and plays out its one or two rows.
// Depends on pjc_pkg and pjc_rsp_if.
`timescale 1ns / 1ps

module pjc_row_out import pjc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  eval_type           eval,
   input  logic [1:0]         joint_mode,
   input  logic signed [31:0] target_distance,
   output logic               free,
   pjc_rsp_if.source          rsp
);

   localparam logic signed [OW-1:0] ONE = OW'(1) <<< FRAC_BITS;

   eval_type         h_ff;
   logic             h_valid_ff;
   logic             h_valid_in;
   logic             h_err_ff;
   logic             h_rev_ff;
   logic [ROW_W-1:0] row_ff;
   logic [ROW_W-1:0] row_in;
   logic             last;
   logic             take;
   logic             load;

   always_comb begin
      last = h_err_ff || !h_rev_ff || (row_ff == ROW_W'(MAX_ROWS - 1));
      take = h_valid_ff && rsp.ready;
      free = !h_valid_ff || (rsp.ready && last);
      load = free && in_valid;
      h_valid_in = load ? 1'b1 : ((take && last) ? 1'b0 : h_valid_ff);
      if (load) begin
         row_in = '0;
      end else if (take && !last) begin
         row_in = row_ff + ROW_W'(1);
      end else begin
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
         row_ff     <= '0;
      end else begin
         h_valid_ff <= h_valid_in;
         row_ff     <= row_in;
      end
   end

   // The user must keep mode and target static while items are in flight; the block does not enforce it.
   always_ff @(posedge clock) begin
      if (load) begin
         h_ff     <= eval;
         h_rev_ff <= (joint_mode == MODE_REVOLUTE);
         h_err_ff <= !((joint_mode == MODE_REVOLUTE)
                    || ((joint_mode == MODE_DISTANCE) && (target_distance > 0)));
      end
   end

   always_comb begin
      rsp.valid            = h_valid_ff;
      rsp.row_index        = row_ff;
      rsp.last_row         = last;
      rsp.error_flag       = h_err_ff;
      rsp.residual_value   = '0;
      rsp.jac_first_x      = '0;
      rsp.jac_first_y      = '0;
      rsp.jac_first_angle  = '0;
      rsp.jac_second_x     = '0;
      rsp.jac_second_y     = '0;
      rsp.jac_second_angle = '0;
      if (h_err_ff) begin
         rsp.row_index = '0;
      end else if (!h_rev_ff) begin
         rsp.residual_value   = h_ff.resid;
         rsp.jac_first_x      = OW'(h_ff.g.dx);
         rsp.jac_first_y      = OW'(h_ff.g.dy);
         rsp.jac_first_angle  = h_ff.ja;
         rsp.jac_second_x     = OW'(-h_ff.g.dx);
         rsp.jac_second_y     = OW'(-h_ff.g.dy);
         rsp.jac_second_angle = h_ff.jb;
      end else if (row_ff == '0) begin
         rsp.residual_value   = OW'(h_ff.g.dx);
         rsp.jac_first_x      = ONE;
         rsp.jac_first_angle  = OW'(-h_ff.g.riy);
         rsp.jac_second_x     = -ONE;
         rsp.jac_second_angle = OW'(h_ff.g.rjy);
      end else begin
         rsp.residual_value   = OW'(h_ff.g.dy);
         rsp.jac_first_y      = ONE;
         rsp.jac_first_angle  = OW'(h_ff.g.rix);
         rsp.jac_second_y     = -ONE;
         rsp.jac_second_angle = OW'(-h_ff.g.rjx);
      end
   end

   a_second_row_revolute: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (row_ff != '0)) |-> (h_rev_ff && !h_err_ff))
      else $error("second row emitted for a single-row item");

   a_error_single_row: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && h_err_ff) |-> (rsp.last_row && (row_ff == '0)))
      else $error("error row is not a lone last row");

   a_row_follows: assert property (@(posedge clock) disable iff (reset)
      (take && !last) |=> (h_valid_ff && (row_ff != '0)))
      else $error("first revolute row not followed by second row");

   a_no_load_while_busy: assert property (@(posedge clock) disable iff (reset)
      (h_valid_ff && !rsp.ready) |=> ($stable(row_ff) && h_valid_ff))
      else $error("held row changed under back-pressure");

endmodule

/* tb/sv/planar_joint_constraint_eval_tb.sv */
// Self-checking testbench for planar_joint_constraint_eval: directed table of
// pose beats, then random beats, each row checked against a local predictor.
// Depends on pjc_pkg, pjc_if and the RTL top level.
`timescale 1ns / 1ps

module planar_joint_constraint_eval_tb;
   import pjc_pkg::*;

   typedef struct packed {
      logic signed [31:0] fx;
      logic signed [31:0] fy;
      logic [15:0]        fa;
      logic signed [31:0] sx;
      logic signed [31:0] sy;
      logic [15:0]        sa;
   } pose_pair_type;

   typedef struct packed {
      logic                 row;
      logic signed [OW-1:0] resid;
      logic signed [OW-1:0] j1x;
      logic signed [OW-1:0] j1y;
      logic signed [OW-1:0] j1a;
      logic signed [OW-1:0] j2x;
      logic signed [OW-1:0] j2y;
      logic signed [OW-1:0] j2a;
      logic                 last;
      logic                 err;
   } joint_row_type;

   // One directed row: a pose pair, plus an optional typed-in first row.
   typedef struct {
      pose_pair_type pose;
      bit            has_known;
      joint_row_type known;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   pjc_req_if req_chan ();
   pjc_rsp_if rsp_chan ();

   planar_joint_constraint_eval u_dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Predictor copy of the register file.
   logic [1:0]         jmode;
   logic signed [31:0] anc_ix, anc_iy, anc_jx, anc_jy, tgt_dist;

   joint_row_type expected_rows[$];
   int  fail_count = 0;
   int  rows_seen = 0;
   int  error_rows = 0;
   bit  quiet = 1'b0;

   localparam logic signed [15:0] QS [65] = '{
      0, 804, 1608, 2410, 3212, 4011, 4808, 5602, 6393, 7179, 7962, 8739, 9512,
      10278, 11039, 11793, 12539, 13279, 14010, 14732, 15446, 16151, 16846, 17530,
      18204, 18868, 19519, 20159, 20787, 21403, 22005, 22594, 23170, 23731, 24279,
      24811, 25329, 25832, 26319, 26790, 27245, 27683, 28105, 28510, 28898, 29268,
      29621, 29956, 30273, 30571, 30852, 31113, 31356, 31580, 31785, 31971, 32137,
      32285, 32412, 32521, 32609, 32678, 32728, 32757, 32767};

   function automatic longint table_sine(input logic [23:0] ph);
      logic [1:0]  quad;
      logic [23:0] p;
      longint      s;
      longint      dstep;
      quad = ph[23:22];
      p = {2'b0, ph[21:0]};
      if (quad[0]) p = 24'h400000 - p;
      if (p[23:16] >= 64) begin
         s = QS[64];
      end else begin
         dstep = QS[p[23:16] + 1] - QS[p[23:16]];
         s = QS[p[23:16]] + ((dstep * p[15:0] + 32768) >>> 16);
      end
      return quad[1] ? -s : s;
   endfunction

   task automatic rotate_local(input logic [15:0] ang, input longint ax, input longint ay,
                               output longint rx, output longint ry);
      logic [23:0] ph;
      longint s, c;
      ph = {ang, 8'd0};
      s = table_sine(ph);
      c = table_sine(ph + 24'h400000);
      rx = (c * ax - s * ay + 16384) >>> 15;
      ry = (s * ax + c * ay + 16384) >>> 15;
   endtask

   function automatic logic signed [OW-1:0] clamp48(input logic signed [127:0] v);
      if (v > 128'sh7FFF_FFFF_FFFF) return {1'b0, {(OW-1){1'b1}}};
      if (v < -128'sh8000_0000_0000) return {1'b1, {(OW-1){1'b0}}};
      return v[OW-1:0];
   endfunction

   function automatic logic signed [OW-1:0] round_clamp(input logic signed [127:0] v,
                                                        input int n);
      logic signed [127:0] t;
      t = (v + (128'sd1 <<< (n - 1))) >>> n;
      return clamp48(t);
   endfunction

   task automatic predict_rows(input pose_pair_type p);
      joint_row_type r0, r1;
      longint rix, riy, rjx, rjy, dx, dy;
      logic signed [127:0] acc;
      r0 = '0;
      r1 = '0;
      if (jmode > MODE_REVOLUTE || (jmode == MODE_DISTANCE && tgt_dist <= 0)) begin
         r0.last = 1'b1;
         r0.err = 1'b1;
         expected_rows.push_back(r0);
         return;
      end
      rotate_local(p.fa, anc_ix, anc_iy, rix, riy);
      rotate_local(p.sa, anc_jx, anc_jy, rjx, rjy);
      dx = (longint'(p.fx) + rix) - (longint'(p.sx) + rjx);
      dy = (longint'(p.fy) + riy) - (longint'(p.sy) + rjy);
      if (jmode == MODE_DISTANCE) begin
         acc = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy)
               - 128'(longint'(tgt_dist)) * 128'(longint'(tgt_dist));
         r0.resid = round_clamp(acc, FRAC_BITS + 1);
         r0.j1x = clamp48(dx);
         r0.j1y = clamp48(dy);
         r0.j1a = round_clamp(-128'(dx) * 128'(riy) + 128'(dy) * 128'(rix), FRAC_BITS);
         r0.j2x = clamp48(-dx);
         r0.j2y = clamp48(-dy);
         r0.j2a = round_clamp(128'(dx) * 128'(rjy) - 128'(dy) * 128'(rjx), FRAC_BITS);
         r0.last = 1'b1;
         expected_rows.push_back(r0);
      end else begin
         r0.resid = clamp48(dx);
         r0.j1x = 48'sd65536;
         r0.j1a = clamp48(-riy);
         r0.j2x = -48'sd65536;
         r0.j2a = clamp48(rjy);
         r1.row = 1'b1;
         r1.resid = clamp48(dy);
         r1.j1y = 48'sd65536;
         r1.j1a = clamp48(rix);
         r1.j2y = -48'sd65536;
         r1.j2a = clamp48(-rjx);
         r1.last = 1'b1;
         expected_rows.push_back(r0);
         expected_rows.push_back(r1);
      end
   endtask

   // Response side: random stall bursts while not quiet; checks every accepted beat.
   initial begin
      int burst;
      rsp_chan.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 3) == 0) begin
            burst = $urandom_range(1, 15);
            rsp_chan.ready <= 1'b0;
            repeat (burst) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      joint_row_type exp_row;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         rows_seen++;
         if (expected_rows.size() == 0) begin
            $error("unexpected response beat");
            fail_count++;
         end else begin
            exp_row = expected_rows.pop_front();
            if (exp_row.err) error_rows++;
            if (rsp_chan.row_index !== exp_row.row) begin
               $error("row_index exp %0d got %0d", exp_row.row, rsp_chan.row_index);
               fail_count++;
            end
            if (rsp_chan.residual_value !== exp_row.resid) begin
               $error("residual_value exp %0d got %0d", exp_row.resid,
                      rsp_chan.residual_value);
               fail_count++;
            end
            if (rsp_chan.jac_first_x !== exp_row.j1x) begin
               $error("jac_first_x exp %0d got %0d", exp_row.j1x, rsp_chan.jac_first_x);
               fail_count++;
            end
            if (rsp_chan.jac_first_y !== exp_row.j1y) begin
               $error("jac_first_y exp %0d got %0d", exp_row.j1y, rsp_chan.jac_first_y);
               fail_count++;
            end
            if (rsp_chan.jac_first_angle !== exp_row.j1a) begin
               $error("jac_first_angle exp %0d got %0d", exp_row.j1a,
                      rsp_chan.jac_first_angle);
               fail_count++;
            end
            if (rsp_chan.jac_second_x !== exp_row.j2x) begin
               $error("jac_second_x exp %0d got %0d", exp_row.j2x, rsp_chan.jac_second_x);
               fail_count++;
            end
            if (rsp_chan.jac_second_y !== exp_row.j2y) begin
               $error("jac_second_y exp %0d got %0d", exp_row.j2y, rsp_chan.jac_second_y);
               fail_count++;
            end
            if (rsp_chan.jac_second_angle !== exp_row.j2a) begin
               $error("jac_second_angle exp %0d got %0d", exp_row.j2a,
                      rsp_chan.jac_second_angle);
               fail_count++;
            end
            if (rsp_chan.last_row !== exp_row.last) begin
               $error("last_row exp %0d got %0d", exp_row.last, rsp_chan.last_row);
               fail_count++;
            end
            if (rsp_chan.error_flag !== exp_row.err) begin
               $error("error_flag exp %0d got %0d", exp_row.err, rsp_chan.error_flag);
               fail_count++;
            end
         end
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [31:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_JOINT_MODE:      jmode = val[1:0];
         CSR_ANCHOR_I_X:      anc_ix = val;
         CSR_ANCHOR_I_Y:      anc_iy = val;
         CSR_ANCHOR_J_X:      anc_jx = val;
         CSR_ANCHOR_J_Y:      anc_jy = val;
         CSR_TARGET_DISTANCE: tgt_dist = val;
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Waits for the pipeline to drain before any register change.
   task automatic drain_pipe();
      while (expected_rows.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic send_pose(input pose_pair_type p);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 15);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.first_pos_x  <= p.fx;
      req_chan.first_pos_y  <= p.fy;
      req_chan.first_angle  <= p.fa;
      req_chan.second_pos_x <= p.sx;
      req_chan.second_pos_y <= p.sy;
      req_chan.second_angle <= p.sa;
      predict_rows(p);
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic end_burst();
      req_chan.valid <= 1'b0;
      drain_pipe();
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2, 3:    return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic pose_pair_type rand_pose();
      pose_pair_type p;
      p.fx = rand_coord();
      p.fy = rand_coord();
      p.fa = 16'($urandom);
      p.sx = rand_coord();
      p.sy = rand_coord();
      p.sa = 16'($urandom);
      return p;
   endfunction

   task automatic rand_config(input int phase);
      write_reg(CSR_JOINT_MODE, (phase % 5 == 4) ? $urandom_range(2, 3)
                                                 : $urandom_range(0, 1));
      write_reg(CSR_ANCHOR_I_X, rand_coord());
      write_reg(CSR_ANCHOR_I_Y, rand_coord());
      write_reg(CSR_ANCHOR_J_X, rand_coord());
      write_reg(CSR_ANCHOR_J_Y, rand_coord());
      write_reg(CSR_TARGET_DISTANCE, ($urandom_range(0, 7) == 0) ? 32'h0 : rand_coord());
   endtask

   directed_row_type dir_rows[$];

   task automatic add_row(input pose_pair_type p, input bit known_err);
      directed_row_type d;
      d.pose = p;
      d.has_known = known_err;
      d.known = '0;
      d.known.last = 1'b1;
      d.known.err = known_err;
      dir_rows.push_back(d);
   endtask

   task automatic run_directed();
      pose_pair_type z, mx, mn;
      joint_row_type got;
      z = '0;
      mx = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 32'h8000_0000, 32'h8000_0000, 16'h0000};
      mn = '{32'h8000_0000, 32'h8000_0000, 16'h4000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hC000};
      // Reset config: distance, zero anchors, unit target; zero poses give -0.5.
      dir_rows.delete();
      add_row(z, 1'b0);
      dir_rows[0].has_known = 1'b1;
      dir_rows[0].known.resid = -48'sd32768;
      add_row(mx, 1'b0);
      add_row(mn, 1'b0);
      foreach (dir_rows[i]) begin
         send_pose(dir_rows[i].pose);
         if (dir_rows[i].has_known) begin
            got = expected_rows[expected_rows.size() - 1];
            if (got !== dir_rows[i].known) begin
               $error("table row %0d: predicted %p typed-in %p", i, got, dir_rows[i].known);
               fail_count++;
            end
         end
      end
      end_burst();
      // Extreme anchors, every angle quadrant, both modes.
      write_reg(CSR_ANCHOR_I_X, 32'h7FFF_FFFF);
      write_reg(CSR_ANCHOR_I_Y, 32'h8000_0000);
      write_reg(CSR_ANCHOR_J_X, 32'h8000_0000);
      write_reg(CSR_ANCHOR_J_Y, 32'h7FFF_FFFF);
      write_reg(CSR_TARGET_DISTANCE, 32'h7FFF_FFFF);
      for (int m = 0; m < 2; m++) begin
         write_reg(CSR_JOINT_MODE, m);
         for (int q = 0; q < 4; q++) begin
            mx.fa = 16'(q * 16'h4000 + 16'h0001);
            mx.sa = 16'(16'hFFFF - q * 16'h4000);
            send_pose(mx);
            send_pose(mn);
         end
         end_burst();
      end
      // Error rows: non-positive targets in distance mode, unsupported modes.
      dir_rows.delete();
      add_row(mx, 1'b1);
      add_row(mn, 1'b1);
      write_reg(CSR_JOINT_MODE, MODE_DISTANCE);
      write_reg(CSR_TARGET_DISTANCE, 32'h0);
      send_pose(mx);
      end_burst();
      write_reg(CSR_TARGET_DISTANCE, 32'h8000_0000);
      send_pose(mn);
      end_burst();
      for (int m = 2; m < 4; m++) begin
         write_reg(CSR_JOINT_MODE, m);
         foreach (dir_rows[i]) begin
            send_pose(dir_rows[i].pose);
            got = expected_rows[expected_rows.size() - 1];
            if (got !== dir_rows[i].known) begin
               $error("table row %0d: predicted %p typed-in %p", i, got, dir_rows[i].known);
               fail_count++;
            end
         end
         end_burst();
      end
   endtask

   initial begin
      int item_count;
      req_chan.valid = 1'b0;
      req_chan.first_pos_x = '0;
      req_chan.first_pos_y = '0;
      req_chan.first_angle = '0;
      req_chan.second_pos_x = '0;
      req_chan.second_pos_y = '0;
      req_chan.second_angle = '0;
      jmode = MODE_DISTANCE;
      anc_ix = 0;
      anc_iy = 0;
      anc_jx = 0;
      anc_jy = 0;
      tgt_dist = 32'sd65536;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      item_count = 0;
      for (int phase = 0; phase < 10; phase++) begin
         rand_config(phase);
         if (phase >= 8) quiet = 1'b1;
         repeat (50) begin
            send_pose(rand_pose());
            item_count++;
         end
         end_burst();
      end
      $display("Covered %0d random pose beats over 10 register settings; %0d rows checked,",
               item_count, rows_seen);
      $display("%0d of them error rows, both joint modes and unsupported modes.",
               error_rows);
      if (fail_count == 0 && expected_rows.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         if (expected_rows.size() != 0) $error("%0d rows never arrived", expected_rows.size());
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/pjc_pkg.sv
rtl/core/pjc_if.sv
rtl/core/pjc_sincos.sv
rtl/core/pjc_rotate.sv
rtl/core/pjc_product.sv
rtl/core/pjc_row_out.sv
rtl/core/planar_joint_constraint_eval.sv
tb/sv/planar_joint_constraint_eval_tb.sv
